FILE: hdl/ptt_pkg.sv
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int SLOT_W = 3;
    localparam int ID_W   = 32;
    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;

    localparam logic [TIME_W-1:0] RESET_TIMEOUT = 32'd5000;

    typedef enum logic [1:0] {
        KIND_ISSUE    = 2'd0,
        KIND_RESPONSE = 2'd1,
        KIND_SWEEP    = 2'd2,
        KIND_CANCEL   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_ACCEPTED  = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_SUCCESS   = 3'd2,
        STATUS_TIMEOUT   = 3'd3,
        STATUS_CANCELLED = 3'd4
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    req_id;
        logic [TIME_W-1:0]  now_time;
        logic [TIME_W-1:0]  timeout;
        logic [TAG_W-1:0]   tag;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot_index;
        logic [ID_W-1:0]    result_id;
        logic [TAG_W-1:0]   result_tag;
        logic               last;
    } result_t;

    // queued job: timeout already resolved into an absolute deadline
    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    req_id;
        logic [TIME_W-1:0]  now_time;
        logic [TIME_W-1:0]  deadline;
        logic [TAG_W-1:0]   tag;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_flags_t;

    // expired when (now - deadline) read as signed is zero or more
    function automatic logic expired(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] diff;
        diff = now - deadline;
        return ~diff[TIME_W-1];
    endfunction

endpackage

FILE: hdl/ptt_front.sv
`timescale 1ns / 1ps

module ptt_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ptt_pkg::cmd_t         cmd,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data,
    input  ptt_pkg::fifo_flags_t  q_flags,
    output logic                  q_push,
    output ptt_pkg::job_t         q_job
);

    logic [ptt_pkg::TIME_W-1:0] default_timeout_reg;
    logic [ptt_pkg::TIME_W-1:0] default_timeout_next;
    logic [ptt_pkg::TIME_W-1:0] offset;

    assign cfg_ready = 1'b1;
    assign busy      = q_flags.full;
    assign q_push    = start && !q_flags.full;

    always_comb
    begin
        default_timeout_next = default_timeout_reg;
        if (cfg_valid && cfg_ready)
        begin
            default_timeout_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_timeout_reg <= ptt_pkg::RESET_TIMEOUT;
        end
        else
        begin
            default_timeout_reg <= default_timeout_next;
        end
    end

    // zero timeout picks the default; deadline wraps mod 2^32
    assign offset = (cmd.timeout != '0) ? cmd.timeout : default_timeout_reg;

    always_comb
    begin
        q_job.kind     = cmd.kind;
        q_job.req_id   = cmd.req_id;
        q_job.now_time = cmd.now_time;
        q_job.deadline = cmd.now_time + offset;
        q_job.tag      = cmd.tag;
    end

endmodule

FILE: hdl/ptt_queue.sv
`timescale 1ns / 1ps

module ptt_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ptt_pkg::job_t         push_job,
    input  logic                  pop,
    output ptt_pkg::job_t         head_job,
    output ptt_pkg::fifo_flags_t  flags
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    ptt_pkg::job_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign flags.full  = (count_reg == CNT_W'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head_job    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hdl/ptt_back.sv
`timescale 1ns / 1ps

module ptt_back
#(
    parameter int SLOTS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptt_pkg::job_t         q_job,
    input  ptt_pkg::fifo_flags_t  q_flags,
    output logic                  q_pop,
    output logic                  strobe,
    output ptt_pkg::result_t      result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    typedef struct packed {
        logic [ptt_pkg::ID_W-1:0]   id;
        logic [ptt_pkg::TIME_W-1:0] deadline;
        logic [ptt_pkg::TAG_W-1:0]  tag;
    } entry_t;

    entry_t entry_mem [SLOTS];

    state_t            state_reg, state_next;
    ptt_pkg::job_t     job_reg, job_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [IW-1:0]     scan_idx_reg, scan_idx_next;
    logic              issuing_reg, issuing_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    entry_t            rd_entry_reg;
    ptt_pkg::result_t  pend_reg, pend_next;
    logic              pend_vld_reg, pend_vld_next;
    logic              strobe_reg, strobe_next;
    ptt_pkg::result_t  result_reg, result_next;

    logic              mem_we;
    logic [IW-1:0]     free_idx;
    logic              table_full;
    logic              rd_expired;
    logic              qual;
    logic              hit;
    ptt_pkg::result_t  hit_result;

    function automatic logic [ptt_pkg::SLOT_W-1:0] slot_code(input logic [IW-1:0] idx);
        logic [IW+ptt_pkg::SLOT_W-1:0] w;
        w = {{ptt_pkg::SLOT_W{1'b0}}, idx};
        return w[ptt_pkg::SLOT_W-1:0];
    endfunction

    assign strobe = strobe_reg;
    assign result = result_reg;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign table_full = &valid_reg;

    // evaluate the entry read out last cycle
    assign rd_expired = ptt_pkg::expired(job_reg.now_time, rd_entry_reg.deadline);

    always_comb
    begin
        unique case (job_reg.kind)
            ptt_pkg::KIND_RESPONSE: qual = (rd_entry_reg.id == job_reg.req_id);
            ptt_pkg::KIND_SWEEP:    qual = rd_expired;
            ptt_pkg::KIND_CANCEL:   qual = 1'b1;
            ptt_pkg::KIND_ISSUE:    qual = 1'b0;
            default:                qual = 1'b0;
        endcase
    end

    assign hit = rd_vld_reg && valid_reg[rd_idx_reg] && qual;

    always_comb
    begin
        if (job_reg.kind == ptt_pkg::KIND_RESPONSE)
        begin
            hit_result.status = rd_expired ? ptt_pkg::STATUS_TIMEOUT
                                           : ptt_pkg::STATUS_SUCCESS;
        end
        else if (job_reg.kind == ptt_pkg::KIND_SWEEP)
        begin
            hit_result.status = ptt_pkg::STATUS_TIMEOUT;
        end
        else
        begin
            hit_result.status = ptt_pkg::STATUS_CANCELLED;
        end
        hit_result.slot_index = slot_code(rd_idx_reg);
        hit_result.result_id  = rd_entry_reg.id;
        hit_result.result_tag = rd_entry_reg.tag;
        hit_result.last       = 1'b0;
    end

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        valid_next    = valid_reg;
        scan_idx_next = scan_idx_reg;
        issuing_next  = issuing_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = scan_idx_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_flags.empty)
                begin
                    q_pop         = 1'b1;
                    job_next      = q_job;
                    scan_idx_next = '0;
                    issuing_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = (q_job.kind == ptt_pkg::KIND_ISSUE) ? ST_ISSUE : ST_SCAN;
                end
            end

            ST_ISSUE:
            begin
                strobe_next            = 1'b1;
                result_next.result_id  = job_reg.req_id;
                result_next.result_tag = job_reg.tag;
                result_next.last       = 1'b1;
                if (table_full)
                begin
                    result_next.status     = ptt_pkg::STATUS_FULL;
                    result_next.slot_index = '0;
                end
                else
                begin
                    mem_we                 = 1'b1;
                    valid_next[free_idx]   = 1'b1;
                    result_next.status     = ptt_pkg::STATUS_ACCEPTED;
                    result_next.slot_index = slot_code(free_idx);
                end
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (issuing_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = scan_idx_reg;
                    if (scan_idx_reg == LAST_SLOT)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IW'(1);
                    end
                end

                if (hit && job_reg.kind == ptt_pkg::KIND_RESPONSE)
                begin
                    // first match ends the search
                    valid_next[rd_idx_reg] = 1'b0;
                    strobe_next            = 1'b1;
                    result_next            = hit_result;
                    result_next.last       = 1'b1;
                    rd_vld_next            = 1'b0;
                    state_next             = ST_IDLE;
                end
                else
                begin
                    if (hit)
                    begin
                        // hold one result back so the final one can carry last
                        valid_next[rd_idx_reg] = 1'b0;
                        if (pend_vld_reg)
                        begin
                            strobe_next = 1'b1;
                            result_next = pend_reg;
                        end
                        pend_next     = hit_result;
                        pend_vld_next = 1'b1;
                    end
                    if (rd_vld_reg && rd_idx_reg == LAST_SLOT)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    strobe_next      = 1'b1;
                    result_next      = pend_reg;
                    result_next.last = 1'b1;
                end
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            issuing_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            issuing_reg  <= issuing_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        pend_reg     <= pend_next;
        result_reg   <= result_next;
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[free_idx] <= '{id:       job_reg.req_id,
                                     deadline: job_reg.deadline,
                                     tag:      job_reg.tag};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= entry_mem[scan_idx_reg];
    end

    a_issue_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |=> strobe_reg && result_reg.last)
        else $error("issue did not give a single final result");

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && (result_reg.status == ptt_pkg::STATUS_ACCEPTED ||
                       result_reg.status == ptt_pkg::STATUS_FULL ||
                       result_reg.status == ptt_pkg::STATUS_SUCCESS) |-> result_reg.last)
        else $error("single-result status without last");

    a_accept_takes_slot: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.status == ptt_pkg::STATUS_ACCEPTED |->
        $countones(valid_reg) == $countones($past(valid_reg)) + 1)
        else $error("accepted issue did not occupy exactly one slot");

    a_flush_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH |=> state_reg == ST_IDLE && !pend_vld_reg)
        else $error("flush left a held result behind");

endmodule

FILE: hdl/pending_request_timeout_table_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// -------   ---  ---------------------   -------------------------------------
// command   in   start && !busy          cmd    (kind, id, now, timeout, tag)
// result    out  strobe, one cycle       result (status, slot, id, tag, last)
// config    in   cfg_valid && cfg_ready  cfg_data (default_timeout)
//
// In the back end an issue is dequeued, then the table is updated with the
// result registered. Response, sweep and cancel walk the entry table one
// slot per cycle through its single read port; a matching response ends the
// walk early. A two-deep command queue sits between front and back end;
// busy is high while it is full. Reset clears all valid bits and the queue
// and sets the default timeout to 5000 ms; no clearing pass is needed.
// Results cannot be stalled: each transaction is on the port for one cycle.

module pending_request_timeout_table_core
#(
    parameter int SLOTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ptt_pkg::cmd_t      cmd,
    output logic               strobe,
    output ptt_pkg::result_t   result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    // front end -> queue -> back end
    ptt_pkg::fifo_flags_t q_flags;
    ptt_pkg::job_t        push_job;
    ptt_pkg::job_t        head_job;
    logic                 q_push;
    logic                 q_pop;

    // Front end: takes command transactions, owns the default timeout and
    // turns each issue's timeout into an absolute wrapping deadline.
    ptt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_flags   (q_flags),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // Short queue so the front end keeps taking transactions while the
    // back end is busy walking the table.
    ptt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .flags    (q_flags)
    );

    // Back end: owns the table (valid flops plus entry memory), allocates
    // slots, matches responses and runs sweep / cancel passes.
    ptt_back #(.SLOTS(SLOTS)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_job   (head_job),
        .q_flags (q_flags),
        .q_pop   (q_pop),
        .strobe  (strobe),
        .result  (result)
    );

endmodule
